FILE: rtl/core/bfsa_pkg.sv
`default_nettype none
// ============================================================================
// bfsa_pkg: shared definitions for the best-fit buffer slot assigner
// Table geometry, field widths and the records passed between the scan
// datapath and the top-level sequencer.
// ============================================================================
package bfsa_pkg;

	// Table geometry and step width
	localparam int MAX_SLOTS = 64;
	localparam int STEP_BITS = 16;

	// Field widths of the request and response channels
	localparam int SIZE_W   = 32;
	localparam int STEP_IN_W = 16;
	localparam int SLOT_OUT_W = 6;
	localparam int POOL_W   = 38;

	// Internal widths derived from the geometry
	localparam int STEP_W = (STEP_BITS < STEP_IN_W) ? STEP_BITS : STEP_IN_W;
	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int WORD_W = SIZE_W + STEP_W;

	// Request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Sequencer to scan datapath: restart and one returning read
	typedef struct packed {
		logic             start;
		logic             rd_valid;
		logic [IDX_W-1:0] rd_idx;
	} scan_ctrl_t;

	// Scan datapath to sequencer: best free slot seen so far
	typedef struct packed {
		logic              pending;
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] cost;
		logic [SIZE_W-1:0] bytes;
	} scan_best_t;

endpackage : bfsa_pkg
`default_nettype wire

FILE: rtl/core/bfsa_req_if.sv
`default_nettype none
// ============================================================================
// bfsa_req_if: request channel of the slot assigner
// Valid/ready channel carrying one allocate or clear request.
// ============================================================================
interface bfsa_req_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [bfsa_pkg::SIZE_W-1:0]      buf_bytes;
	logic [bfsa_pkg::STEP_IN_W-1:0]   first_use;
	logic [bfsa_pkg::STEP_IN_W-1:0]   last_use;

	modport source (output valid, kind, buf_bytes, first_use, last_use, input ready);
	modport sink   (input valid, kind, buf_bytes, first_use, last_use, output ready);
endinterface : bfsa_req_if
`default_nettype wire

FILE: rtl/core/bfsa_rsp_if.sv
`default_nettype none
// ============================================================================
// bfsa_rsp_if: response channel of the slot assigner
// Valid/ready channel carrying one placement result per request.
// ============================================================================
interface bfsa_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [bfsa_pkg::SLOT_OUT_W-1:0]   slot_index;
	logic                              slot_is_new;
	logic                              overflow;
	logic [bfsa_pkg::POOL_W-1:0]       pool_total_bytes;

	modport source (output valid, slot_index, slot_is_new, overflow, pool_total_bytes,
		input ready);
	modport sink   (input valid, slot_index, slot_is_new, overflow, pool_total_bytes,
		output ready);
endinterface : bfsa_rsp_if
`default_nettype wire

FILE: rtl/core/bfsa_ram.sv
`default_nettype none
// ============================================================================
// bfsa_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data follows re in the next cycle.
// ============================================================================
module bfsa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : bfsa_ram
`default_nettype wire

FILE: rtl/core/bfsa_scan.sv
`default_nettype none
// ============================================================================
// bfsa_scan: best-fit search datapath
// Takes one slot word per cycle from the table, works out whether the slot is
// free and its growth cost, and keeps the cheapest free slot (lowest index
// on a tie).
// ============================================================================
module bfsa_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bfsa_pkg::scan_ctrl_t            ctrl,
	input  wire logic [bfsa_pkg::WORD_W-1:0]     rd_word,
	input  wire logic [bfsa_pkg::SIZE_W-1:0]     size,
	input  wire logic [bfsa_pkg::STEP_W-1:0]     first,
	output bfsa_pkg::scan_best_t                 best
);
	import bfsa_pkg::*;

	logic [SIZE_W-1:0] slot_bytes;
	logic [STEP_W-1:0] slot_busy;
	logic              free_c;
	logic [SIZE_W-1:0] cost_c;

	logic              valid_s2;
	logic              free_s2;
	logic [SIZE_W-1:0] cost_s2;
	logic [SIZE_W-1:0] bytes_s2;
	logic [IDX_W-1:0]  idx_s2;

	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SIZE_W-1:0] low_cost_q;
	logic [SIZE_W-1:0] best_bytes_q;

	// Split the word and work out freeness and growth cost
	always_comb begin
		slot_bytes = rd_word[WORD_W-1:STEP_W];
		slot_busy  = rd_word[STEP_W-1:0];
		free_c     = slot_busy < first;
		cost_c     = (size > slot_bytes) ? (size - slot_bytes) : '0;
	end

	// Hold the evaluated slot for the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctrl.rd_valid && !ctrl.start;
		end
	end

	always_ff @(posedge clk) begin
		free_s2  <= free_c;
		cost_s2  <= cost_c;
		bytes_s2 <= slot_bytes;
		idx_s2   <= ctrl.rd_idx;
	end

	// Keep the cheapest free slot; only a strictly lower cost replaces it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
		end else if (valid_s2 && free_s2 && (!found_q || cost_s2 < low_cost_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && free_s2 && (!found_q || cost_s2 < low_cost_q)) begin
			best_idx_q   <= idx_s2;
			low_cost_q   <= cost_s2;
			best_bytes_q <= bytes_s2;
		end
	end

	assign best.pending = valid_s2;
	assign best.found   = found_q;
	assign best.idx     = best_idx_q;
	assign best.cost    = low_cost_q;
	assign best.bytes   = best_bytes_q;

endmodule : bfsa_scan
`default_nettype wire

FILE: rtl/core/best_fit_buffer_slot_assigner.sv
`default_nettype none
// ============================================================================
// best_fit_buffer_slot_assigner: best-fit buffer slot assigner top level
// Places buffer lifetimes into a slot table held in one synchronous RAM.
// ============================================================================
// Usage:
//   req carries one request: kind allocate with buf_bytes, first_use and
//   last_use, or kind clear, which empties the table. rsp returns one result
//   per request: slot_index, slot_is_new, overflow and pool_total_bytes.
//   An allocate request reads every slot in use, one RAM read per cycle, and
//   keeps the cheapest free slot; it then grows or appends a slot and writes
//   the entry back. A clear request goes straight to the decide state. One
//   request is in work at a time and req.ready is high only while the
//   sequencer is idle.
//   The result sits in an output register, so the next request is taken
//   while the previous result waits. If rsp.ready stays low, the sequencer
//   holds its finished result until the output register is free.
//   Reset empties the table and zeroes the pool total; the RAM needs no
//   clearing pass since only slots below the fill count are read.
// ============================================================================
module best_fit_buffer_slot_assigner (
	input wire logic  clk,
	input wire logic  arst_n,
	bfsa_req_if.sink  req,
	bfsa_rsp_if.source rsp
);
	import bfsa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  used_q;
	logic [POOL_W-1:0] pool_q;
	logic [CNT_W-1:0]  addr_q;
	logic              kind_q;
	logic [SIZE_W-1:0] size_q;
	logic [STEP_W-1:0] first_q;
	logic [STEP_W-1:0] last_q;

	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] out_idx_q;
	logic                  out_new_q;
	logic                  out_ovf_q;
	logic [POOL_W-1:0]     out_pool_q;

	logic              rd_valid_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              accept;
	logic              re;
	logic              out_free;
	logic              decide;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;
	logic [SIZE_W-1:0] grow;
	logic [POOL_W:0]   pool_sum;
	logic [POOL_W-1:0] pool_next;
	logic              has_room;

	scan_ctrl_t ctrl;
	scan_best_t best;

	// Handshake and read issue
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign re       = (state_q == ST_SCAN) && (addr_q < used_q);
	assign out_free = !out_valid_q || rsp.ready;
	assign decide   = (state_q == ST_DECIDE) && out_free;
	assign has_room = used_q < CNT_W'(MAX_SLOTS);

	// Write back: grow the best slot, or append a new one
	always_comb begin
		we    = 1'b0;
		waddr = best.idx;
		wdata = {size_q, last_q};
		grow  = '0;
		if (decide && kind_q == KIND_ALLOC) begin
			if (best.found) begin
				we    = 1'b1;
				waddr = best.idx;
				wdata = {(best.cost != '0) ? size_q : best.bytes, last_q};
				grow  = best.cost;
			end else if (has_room) begin
				we    = 1'b1;
				waddr = used_q[IDX_W-1:0];
				grow  = size_q;
			end
		end
	end

	// Saturating pool accumulate
	always_comb begin
		pool_sum  = {1'b0, pool_q} + (POOL_W + 1)'(grow);
		pool_next = pool_sum[POOL_W] ? '1 : pool_sum[POOL_W-1:0];
	end

	// Track reads returning from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
	end

	assign ctrl.start    = accept;
	assign ctrl.rd_valid = rd_valid_s1;
	assign ctrl.rd_idx   = rd_idx_s1;

	// Sequencer, table counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			pool_q      <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_new_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_pool_q  <= '0;
		end else begin
			if (rsp.valid && rsp.ready && !decide) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						state_q <= (req.kind == KIND_CLEAR) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (re) begin
						addr_q <= addr_q + 1'b1;
					end else if (!rd_valid_s1 && !best.pending) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (kind_q == KIND_CLEAR) begin
							used_q     <= '0;
							pool_q     <= '0;
							out_pool_q <= '0;
							out_idx_q  <= '0;
							out_new_q  <= 1'b0;
							out_ovf_q  <= 1'b0;
						end else if (best.found) begin
							pool_q     <= pool_next;
							out_pool_q <= pool_next;
							out_idx_q  <= SLOT_OUT_W'(best.idx);
							out_new_q  <= 1'b0;
							out_ovf_q  <= 1'b0;
						end else if (has_room) begin
							used_q     <= used_q + 1'b1;
							pool_q     <= pool_next;
							out_pool_q <= pool_next;
							out_idx_q  <= SLOT_OUT_W'(used_q);
							out_new_q  <= 1'b1;
							out_ovf_q  <= 1'b0;
						end else begin
							out_pool_q <= pool_q;
							out_idx_q  <= '0;
							out_new_q  <= 1'b0;
							out_ovf_q  <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request fields, reduced to the step width
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			size_q  <= req.buf_bytes;
			first_q <= req.first_use[STEP_W-1:0];
			last_q  <= req.last_use[STEP_W-1:0];
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.slot_index       = out_idx_q;
	assign rsp.slot_is_new      = out_new_q;
	assign rsp.overflow         = out_ovf_q;
	assign rsp.pool_total_bytes = out_pool_q;

	bfsa_ram #(
		.DEPTH (MAX_SLOTS),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	bfsa_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_word (rdata),
		.size    (size_q),
		.first   (first_q),
		.best    (best)
	);

endmodule : best_fit_buffer_slot_assigner
`default_nettype wire

FILE: tb/bfsa_placement_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bfsa_placement_checker: scoreboard for the best-fit buffer slot assigner
// Watches the request and response channels and keeps its own copy of the
// slot table. Each accepted request is placed in that table and the
// expected placement is queued. Each accepted response is checked, field by
// field, against the oldest queued placement.
// ============================================================================
module bfsa_placement_checker (
	input wire logic clk,
	input wire logic arst_n,
	bfsa_req_if      req,
	bfsa_rsp_if      rsp,
	output int       fail_count,
	output int       outstanding
);
	import bfsa_pkg::*;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  is_new;
		logic                  ovf;
		logic [POOL_W-1:0]     pool;
	} placement_t;

	localparam logic [POOL_W-1:0] POOL_MAX = '1;

	// Shadow slot table
	logic [SIZE_W-1:0] slot_size  [MAX_SLOTS];
	logic [STEP_W-1:0] slot_until [MAX_SLOTS];
	int unsigned       fill_count;
	logic [POOL_W-1:0] pool_bytes;
	placement_t        placement_q [$];

	// Add growth to the pool total, saturating at full scale
	function automatic logic [POOL_W-1:0] grow_pool(input logic [POOL_W-1:0] grow);
		return (grow > POOL_MAX - pool_bytes) ? POOL_MAX : pool_bytes + grow;
	endfunction

	// Place one lifetime in the shadow table and return the placement
	function automatic placement_t place_lifetime(
		input logic                 kind,
		input logic [SIZE_W-1:0]    size,
		input logic [STEP_IN_W-1:0] first_raw,
		input logic [STEP_IN_W-1:0] last_raw
	);
		placement_t        p;
		logic [STEP_W-1:0] first;
		logic [STEP_W-1:0] last;
		logic [SIZE_W-1:0] cost;
		logic [SIZE_W-1:0] low_cost;
		bit                found;
		int unsigned       best;
		int unsigned       s;
		p        = '0;
		first    = first_raw[STEP_W-1:0];
		last     = last_raw[STEP_W-1:0];
		found    = 1'b0;
		best     = 0;
		low_cost = '0;
		if (kind == KIND_CLEAR) begin
			fill_count = 0;
			pool_bytes = '0;
		end else begin
			// scan the slots in use for the cheapest free one, lowest index on a tie
			for (s = 0; s < fill_count; s++) begin
				if (slot_until[s] < first) begin
					cost = (size > slot_size[s]) ? size - slot_size[s] : '0;
					if (!found || cost < low_cost) begin
						found    = 1'b1;
						best     = s;
						low_cost = cost;
					end
				end
			end
			if (found) begin
				if (size > slot_size[best]) begin
					pool_bytes      = grow_pool(POOL_W'(size - slot_size[best]));
					slot_size[best] = size;
				end
				slot_until[best] = last;
				p.slot           = SLOT_OUT_W'(best);
			end else if (fill_count < MAX_SLOTS) begin
				slot_size[fill_count]  = size;
				slot_until[fill_count] = last;
				p.slot                 = SLOT_OUT_W'(fill_count);
				p.is_new               = 1'b1;
				fill_count++;
				pool_bytes = grow_pool(POOL_W'(size));
			end else begin
				p.ovf = 1'b1;
			end
		end
		p.pool = pool_bytes;
		return p;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Predict on each accepted request, compare on each accepted response
	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			fill_count  = 0;
			pool_bytes  = '0;
			fail_count  = 0;
			outstanding = 0;
			placement_q.delete();
		end else begin
			if (req.valid && req.ready)
				placement_q.insert(placement_q.size(), place_lifetime(req.kind,
					req.buf_bytes, req.first_use, req.last_use));
			if (rsp.valid && rsp.ready) begin
				if (placement_q.size() == 0) begin
					$display("%0t: stray response, expected none, got slot %0d pool %0d",
						$time, rsp.slot_index, rsp.pool_total_bytes);
					fail_count++;
				end else begin
					want = placement_q.pop_front();
					check_field("slot_index", want.slot, rsp.slot_index);
					check_field("slot_is_new", want.is_new, rsp.slot_is_new);
					check_field("overflow", want.ovf, rsp.overflow);
					check_field("pool_total_bytes", want.pool, rsp.pool_total_bytes);
				end
			end
			outstanding = placement_q.size();
		end
	end

endmodule : bfsa_placement_checker

FILE: tb/tb_best_fit_buffer_slot_assigner.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_best_fit_buffer_slot_assigner: testbench top for the slot assigner
// Drives a short directed list of requests and then random lifetime sets:
// sorted and unsorted graphs, table-filling pile-ups and raw noise, with
// random gaps on the request side and random stalls on the response side.
// The placement checker predicts and compares; this module gives the verdict.
// ============================================================================
module tb_best_fit_buffer_slot_assigner;
	import bfsa_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = MAX_SLOTS + 40;
	localparam int TOTAL_ITEMS  = 1140;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycle_count;
	int   requests_sent;
	bit   src_idle_on;
	bit   sink_idle_on;

	bfsa_req_if req_ch ();
	bfsa_rsp_if rsp_ch ();

	best_fit_buffer_slot_assigner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bfsa_placement_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[best_fit_buffer_slot_assigner] ERROR");
		$finish;
	end

	// Send one request, holding valid until it is taken
	task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
		input logic [STEP_IN_W-1:0] first, input logic [STEP_IN_W-1:0] last);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.buf_bytes  <= size;
		req_ch.first_use  <= first;
		req_ch.last_use   <= last;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
	endtask

	task automatic alloc(input logic [SIZE_W-1:0] size, input logic [STEP_IN_W-1:0] first,
		input logic [STEP_IN_W-1:0] last);
		send_request(KIND_ALLOC, size, first, last);
	endtask

	// Clear with random content in the ignored fields
	task automatic clear_table();
		send_request(KIND_CLEAR, $urandom, STEP_IN_W'($urandom), STEP_IN_W'($urandom));
	endtask

	// One graph's worth of lifetimes over a narrow step window
	task automatic run_graph(input int count, input bit sorted, input bit wide);
		logic [SIZE_W-1:0]    size;
		logic [STEP_IN_W-1:0] base;
		logic [STEP_IN_W-1:0] first;
		logic [STEP_IN_W-1:0] last;
		int                   i;
		size = wide ? $urandom : $urandom_range(16, 65536);
		base = STEP_IN_W'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 32));
		for (i = 0; i < count; i++) begin
			if (!sorted)
				size = wide ? $urandom : $urandom_range(0, 65536);
			first = STEP_IN_W'(base + $urandom_range(0, count + 4));
			// now and then store a lifetime that ends before it starts
			last = ($urandom_range(0, 15) == 0) ? STEP_IN_W'(first - $urandom_range(1, 8))
				: STEP_IN_W'(first + $urandom_range(0, 10));
			alloc(size, first, last);
			// shrink, or keep the size to give ties
			if (sorted && $urandom_range(0, 2) != 0)
				size = size - (size >> $urandom_range(1, 8));
		end
	endtask

	// All lifetimes start at step zero, so none reuses a slot: fills the table
	task automatic run_pile_up(input int count);
		logic [SIZE_W-1:0] size;
		int                i;
		size = $urandom;
		for (i = 0; i < count; i++) begin
			alloc(size, '0, STEP_IN_W'($urandom));
			size = size - (size >> 4);
		end
	endtask

	task automatic run_noise(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				clear_table();
			else
				alloc($urandom, STEP_IN_W'($urandom), STEP_IN_W'($urandom));
		end
	endtask

	// Response side: random stalls, with stretches of none
	initial begin
		int stall;
		int taken;
		taken        = 0;
		sink_idle_on = 1'b1;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				sink_idle_on = ($urandom_range(0, 2) != 0);
			stall = sink_idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
		end
	end

	// Request side and verdict
	initial begin
		int pick;
		requests_sent     = 0;
		src_idle_on       = 1'b0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= KIND_ALLOC;
		req_ch.buf_bytes  <= '0;
		req_ch.first_use  <= '0;
		req_ch.last_use   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, growth, reuse, ties, reversed lifetime, clear
		clear_table();
		alloc(32'd0, 16'd0, 16'd0);
		alloc(32'hFFFF_FFFF, 16'd0, 16'hFFFF);
		alloc(32'd5, 16'd1, 16'd3);
		alloc(32'd5, 16'hFFFF, 16'hFFFF);
		alloc(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
		alloc(32'd100, 16'd1, 16'd2);
		clear_table();
		alloc(32'd10, 16'd0, 16'd1);
		alloc(32'd10, 16'd0, 16'd1);
		alloc(32'd8, 16'd5, 16'd6);
		alloc(32'd20, 16'd10, 16'd11);
		alloc(32'd9, 16'd22, 16'd100);
		alloc(32'd15, 16'd30, 16'd31);
		alloc(32'd16, 16'd200, 16'd201);
		alloc(32'd30, 16'd300, 16'd301);
		alloc(32'h5555_5555, 16'hAAAA, 16'h5555);
		alloc(32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
		clear_table();
		alloc(32'd7, 16'd3, 16'd4);

		// Random: start with a full table, then work it without clearing
		run_pile_up(66);
		run_graph(16, 1'b1, 1'b0);
		while (requests_sent < TOTAL_ITEMS) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			pick        = $urandom_range(0, 19);
			if (pick < 15) begin
				if ($urandom_range(0, 4) != 0)
					clear_table();
				run_graph(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
					: $urandom_range(1, 16), pick < 12, 1'($urandom_range(0, 1)));
			end else if (pick < 16) begin
				if ($urandom_range(0, 3) != 0)
					clear_table();
				run_pile_up($urandom_range(60, 70));
			end else begin
				run_noise($urandom_range(1, 10));
			end
		end
		req_ch.valid <= 1'b0;

		// Drain the remaining responses, then watch for strays
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("[best_fit_buffer_slot_assigner] OK");
		else
			$display("[best_fit_buffer_slot_assigner] ERROR");
		$finish;
	end

endmodule : tb_best_fit_buffer_slot_assigner

FILE: best_fit_buffer_slot_assigner.f
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_req_if.sv
rtl/core/bfsa_rsp_if.sv
rtl/core/bfsa_ram.sv
rtl/core/bfsa_scan.sv
rtl/core/best_fit_buffer_slot_assigner.sv
tb/bfsa_placement_checker.sv
tb/tb_best_fit_buffer_slot_assigner.sv
